// ===== sv/dur2sec_pkg.sv =====
// shared types, character codes and constants for the duration string parser
package dur2sec_pkg;

  // one input beat: a character and the end-of-string mark
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic signed [63:0] seconds;
    logic [1:0]         status;
  } out_beat_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_DIV,
    S_ACC
  } state_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_NO_NUMBER = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // ascii codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_S     = 8'h53;

  // unit factors in seconds
  localparam int unsigned FACT_W = 25;
  localparam logic [FACT_W-1:0] FACT_YEAR   = 25'd31540000;
  localparam logic [FACT_W-1:0] FACT_MONTH  = 25'd2628000;
  localparam logic [FACT_W-1:0] FACT_DAY    = 25'd86400;
  localparam logic [FACT_W-1:0] FACT_HOUR   = 25'd3600;
  localparam logic [FACT_W-1:0] FACT_MINUTE = 25'd60;
  localparam logic [FACT_W-1:0] FACT_SECOND = 25'd1;

  // fraction digits kept after the point, at most six
  localparam int unsigned MAX_FRAC_DIGITS = 6;
  localparam int unsigned FC_W = 4;

  // largest power of ten used as divisor fits in this many bits
  localparam int unsigned P_W = 30;

  // largest magnitude of the result
  localparam logic [62:0] MAG_MAX = {63{1'b1}};

  // divisor for a given count of fraction digits
  function automatic logic [P_W-1:0] pow_ten(input logic [FC_W-1:0] fc);
    logic [P_W-1:0] p;
    case (fc)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/duration_string_to_seconds_top.sv =====
// duration string parser: characters in, signed fixed point seconds out
//
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  input   | in_valid  in_stall  in_data    | one character, last mark
//  output  | out_valid out_stall out_data   | seconds (q.FRAC_BITS), status
//
// digits, points, 'T' and ignored characters are taken in the idle state
// a unit letter with a number runs the sequencer through two multiply
// steps, an add, the bit-serial restoring divider by 10^k and an accumulate
// the two multiply steps share one 25 by (MANTISSA_BITS+1)/2 multiplier
// reset clears the parser state; the output register holds its beat while
// out_stall is high; the input stalls while busy and until it can take a result
module duration_string_to_seconds_top #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned MANTISSA_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dur2sec_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dur2sec_pkg::out_beat_t out_data
);

  localparam int unsigned MB     = MANTISSA_BITS;
  localparam int unsigned HALF   = (MB + 1) / 2;
  localparam int unsigned FW     = dur2sec_pkg::FACT_W;
  localparam int unsigned PP_W   = HALF + FW;
  localparam int unsigned PROD_W = MB + FW;
  localparam int unsigned DW     = PROD_W + FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(DW);
  localparam int unsigned PW     = dur2sec_pkg::P_W;
  localparam int unsigned FCW    = dur2sec_pkg::FC_W;

  dur2sec_pkg::state_t state_r, state_nxt;

  // parser state
  logic             start_r, start_nxt;
  logic             neg_r, neg_nxt;
  logic             time_r, time_nxt;
  logic [MB-1:0]    mant_r, mant_nxt;
  logic [FCW-1:0]   fc_r, fc_nxt;
  logic [1:0]       pt_r, pt_nxt;
  logic             hd_r, hd_nxt;
  logic [62:0]      total_r, total_nxt;
  logic [1:0]       err_r, err_nxt;

  // unit datapath
  logic [FW-1:0]    fact_r, fact_nxt;
  logic             last_r, last_nxt;
  logic [PP_W-1:0]  pp_r, pp_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [DW-1:0]    div_r, div_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [63:0]      q_r, q_nxt;
  logic             qovf_r, qovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  dur2sec_pkg::out_beat_t out_data_r, out_data_nxt;

  // character decode results
  logic             start_t, neg_t, time_t, hd_t, go_unit;
  logic [MB-1:0]    mant_t;
  logic [FCW-1:0]   fc_t;
  logic [1:0]       pt_t, err_t;
  logic [FW-1:0]    fact_sel;
  logic             is_unit;
  logic [MB+3:0]    ten_sum;
  logic             in_acc;

  // divider and accumulate terms
  logic [PW-1:0]    p_cur;
  logic [PW:0]      trial;
  logic             trial_ge;
  logic [62:0]      term_val;
  logic [63:0]      sum_tot;
  logic             acc_sat;

  function automatic dur2sec_pkg::out_beat_t make_result(input logic [1:0] err,
                                                         input logic neg,
                                                         input logic [62:0] tot);
    dur2sec_pkg::out_beat_t r;
    r.status = err;
    if (err == dur2sec_pkg::ST_BAD_START || err == dur2sec_pkg::ST_NO_NUMBER) begin
      r.seconds = '0;
    end else if (err == dur2sec_pkg::ST_OVERFLOW) begin
      r.seconds = neg ? {1'b1, 63'd0} : {1'b0, dur2sec_pkg::MAG_MAX};
    end else begin
      r.seconds = neg ? -$signed({1'b0, tot}) : $signed({1'b0, tot});
    end
    return r;
  endfunction

  // handshake
  assign in_stall  = (state_r != dur2sec_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // mantissa times ten plus the new digit
  assign ten_sum = {1'b0, mant_r, 3'b000} + {3'b000, mant_r, 1'b0}
                 + {{MB{1'b0}}, in_data.ch[3:0]};

  // decode of one character against the current parser state
  always_comb begin
    start_t  = start_r;
    neg_t    = neg_r;
    time_t   = time_r;
    mant_t   = mant_r;
    fc_t     = fc_r;
    pt_t     = pt_r;
    hd_t     = hd_r;
    err_t    = err_r;
    go_unit  = 1'b0;
    is_unit  = 1'b0;
    fact_sel = dur2sec_pkg::FACT_SECOND;
    if (start_r) begin
      start_t = 1'b0;
      if (in_data.ch == dur2sec_pkg::CH_MINUS) begin
        neg_t = 1'b1;
      end else if (in_data.ch != dur2sec_pkg::CH_P) begin
        err_t = dur2sec_pkg::ST_BAD_START;
      end
    end else if (err_r == dur2sec_pkg::ST_BAD_START || err_r == dur2sec_pkg::ST_NO_NUMBER) begin
      // rest of the string is ignored
    end else if (in_data.ch >= dur2sec_pkg::CH_ZERO && in_data.ch <= dur2sec_pkg::CH_NINE) begin
      if (pt_r == 2'd2) begin
        // digits after a second point are dropped
      end else if (pt_r == 2'd1 && fc_r >= FCW'(dur2sec_pkg::MAX_FRAC_DIGITS)) begin
        // fraction digits beyond the limit are dropped
      end else begin
        if (|ten_sum[MB+3:MB]) begin
          mant_t = '1;
          err_t  = dur2sec_pkg::ST_OVERFLOW;
        end else begin
          mant_t = ten_sum[MB-1:0];
        end
        hd_t = 1'b1;
        if (pt_r == 2'd1) begin
          fc_t = fc_r + FCW'(1);
        end
      end
    end else begin
      case (in_data.ch)
        dur2sec_pkg::CH_DOT: begin
          if (pt_r != 2'd2) begin
            pt_t = pt_r + 2'd1;
          end
        end
        dur2sec_pkg::CH_T: time_t = 1'b1;
        dur2sec_pkg::CH_Y: begin
          is_unit  = 1'b1;
          fact_sel = dur2sec_pkg::FACT_YEAR;
        end
        dur2sec_pkg::CH_M: begin
          is_unit  = 1'b1;
          fact_sel = time_r ? dur2sec_pkg::FACT_MINUTE : dur2sec_pkg::FACT_MONTH;
        end
        dur2sec_pkg::CH_D: begin
          is_unit  = 1'b1;
          fact_sel = dur2sec_pkg::FACT_DAY;
        end
        dur2sec_pkg::CH_H: begin
          is_unit  = 1'b1;
          fact_sel = dur2sec_pkg::FACT_HOUR;
        end
        dur2sec_pkg::CH_S: begin
          is_unit  = 1'b1;
          fact_sel = dur2sec_pkg::FACT_SECOND;
        end
        default: ;
      endcase
      if (is_unit) begin
        if (hd_r) begin
          go_unit = 1'b1;
        end else begin
          err_t = dur2sec_pkg::ST_NO_NUMBER;
        end
      end
    end
  end

  // divider step and final accumulate terms
  assign p_cur    = dur2sec_pkg::pow_ten(fc_r);
  assign trial    = {rem_r, div_r[DW-1]};
  assign trial_ge = trial >= {1'b0, p_cur};
  assign term_val = (qovf_r || q_r[63]) ? dur2sec_pkg::MAG_MAX : q_r[62:0];
  assign sum_tot  = {1'b0, total_r} + {1'b0, term_val};
  assign acc_sat  = qovf_r || q_r[63] || sum_tot[63];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dur2sec_pkg::S_IDLE: begin
        if (in_acc && go_unit) begin
          state_nxt = dur2sec_pkg::S_MUL_LO;
        end
      end
      dur2sec_pkg::S_MUL_LO: state_nxt = dur2sec_pkg::S_MUL_HI;
      dur2sec_pkg::S_MUL_HI: state_nxt = dur2sec_pkg::S_ADD;
      dur2sec_pkg::S_ADD:    state_nxt = dur2sec_pkg::S_DIV;
      dur2sec_pkg::S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = dur2sec_pkg::S_ACC;
        end
      end
      dur2sec_pkg::S_ACC:    state_nxt = dur2sec_pkg::S_IDLE;
      default:               state_nxt = dur2sec_pkg::S_IDLE;
    endcase
  end

  // datapath and output register updates
  always_comb begin
    start_nxt     = start_r;
    neg_nxt       = neg_r;
    time_nxt      = time_r;
    mant_nxt      = mant_r;
    fc_nxt        = fc_r;
    pt_nxt        = pt_r;
    hd_nxt        = hd_r;
    total_nxt     = total_r;
    err_nxt       = err_r;
    fact_nxt      = fact_r;
    last_nxt      = last_r;
    pp_nxt        = pp_r;
    acc_nxt       = acc_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    qovf_nxt      = qovf_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      dur2sec_pkg::S_IDLE: begin
        if (in_acc) begin
          fact_nxt = fact_sel;
          last_nxt = in_data.last;
          if (in_data.last && !go_unit) begin
            // end of string: give the result and start over
            out_valid_nxt = 1'b1;
            out_data_nxt  = make_result(err_t, neg_t, total_r);
            start_nxt     = 1'b1;
            neg_nxt       = 1'b0;
            time_nxt      = 1'b0;
            mant_nxt      = '0;
            fc_nxt        = '0;
            pt_nxt        = '0;
            hd_nxt        = 1'b0;
            total_nxt     = '0;
            err_nxt       = dur2sec_pkg::ST_OK;
          end else begin
            start_nxt = start_t;
            neg_nxt   = neg_t;
            time_nxt  = time_t;
            mant_nxt  = mant_t;
            fc_nxt    = fc_t;
            pt_nxt    = pt_t;
            hd_nxt    = hd_t;
            err_nxt   = err_t;
          end
        end
      end
      dur2sec_pkg::S_MUL_LO: begin
        pp_nxt = PP_W'(mant_r[HALF-1:0]) * PP_W'(fact_r);
      end
      dur2sec_pkg::S_MUL_HI: begin
        acc_nxt = PROD_W'(pp_r);
        pp_nxt  = PP_W'(mant_r[MB-1:HALF]) * PP_W'(fact_r);
      end
      dur2sec_pkg::S_ADD: begin
        div_nxt  = {acc_r + (PROD_W'(pp_r) << HALF), {FRAC_BITS{1'b0}}};
        rem_nxt  = '0;
        q_nxt    = '0;
        qovf_nxt = 1'b0;
        cnt_nxt  = CNT_W'(DW - 1);
      end
      dur2sec_pkg::S_DIV: begin
        // one quotient bit per cycle
        rem_nxt  = trial_ge ? PW'(trial - {1'b0, p_cur}) : trial[PW-1:0];
        div_nxt  = div_r << 1;
        q_nxt    = {q_r[62:0], trial_ge};
        qovf_nxt = qovf_r || q_r[63];
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      dur2sec_pkg::S_ACC: begin
        total_nxt = acc_sat ? dur2sec_pkg::MAG_MAX : sum_tot[62:0];
        err_nxt   = acc_sat ? dur2sec_pkg::ST_OVERFLOW : err_r;
        mant_nxt  = '0;
        fc_nxt    = '0;
        pt_nxt    = '0;
        hd_nxt    = 1'b0;
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = make_result(acc_sat ? dur2sec_pkg::ST_OVERFLOW : err_r, neg_r,
                                      sum_tot[62:0]);
          start_nxt     = 1'b1;
          neg_nxt       = 1'b0;
          time_nxt      = 1'b0;
          total_nxt     = '0;
          err_nxt       = dur2sec_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control and parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dur2sec_pkg::S_IDLE;
      start_r     <= 1'b1;
      neg_r       <= 1'b0;
      time_r      <= 1'b0;
      mant_r      <= '0;
      fc_r        <= '0;
      pt_r        <= '0;
      hd_r        <= 1'b0;
      total_r     <= '0;
      err_r       <= dur2sec_pkg::ST_OK;
      last_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      neg_r       <= neg_nxt;
      time_r      <= time_nxt;
      mant_r      <= mant_nxt;
      fc_r        <= fc_nxt;
      pt_r        <= pt_nxt;
      hd_r        <= hd_nxt;
      total_r     <= total_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    fact_r     <= fact_nxt;
    pp_r       <= pp_nxt;
    acc_r      <= acc_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    qovf_r     <= qovf_nxt;
    out_data_r <= out_data_nxt;
  end

  // remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dur2sec_pkg::S_DIV |-> rem_r < p_cur)
    else $error("divider remainder not below divisor");

  // a unit letter with a number starts the multiply
  a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dur2sec_pkg::S_IDLE && in_acc && go_unit) |=> state_r == dur2sec_pkg::S_MUL_LO)
    else $error("unit letter did not start the sequencer");

  // the sequencer only runs on a pending number
  a_busy_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != dur2sec_pkg::S_IDLE |-> hd_r)
    else $error("sequencer busy without a pending number");

  // the output register is free when a last unit finishes
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dur2sec_pkg::S_ACC && last_r) |-> !out_valid_r)
    else $error("result would overwrite a pending beat");

endmodule
